// ----- design/scsc_pkg.sv -----
// ----------------------------------------------------------------------------
// Shadow call stack checker package
// Event codes, result status codes and sequencer states.
// ----------------------------------------------------------------------------
package scsc_pkg;

	localparam int DATA_W   = 64;
	localparam int STATUS_W = 4;
	localparam int POS_W    = 6;
	localparam int RELOC_W  = 32;

	localparam logic [1:0] ACT_CALL  = 2'd0;
	localparam logic [1:0] ACT_RET   = 2'd1;
	localparam logic [1:0] ACT_WRITE = 2'd2;

	localparam logic [STATUS_W-1:0] STS_CALL_PUSHED  = 4'd0;
	localparam logic [STATUS_W-1:0] STS_CALL_DROPPED = 4'd1;
	localparam logic [STATUS_W-1:0] STS_RET_TOP      = 4'd2;
	localparam logic [STATUS_W-1:0] STS_RET_BELOW    = 4'd3;
	localparam logic [STATUS_W-1:0] STS_PUSH_POP     = 4'd4;
	localparam logic [STATUS_W-1:0] STS_RELOCATED    = 4'd5;
	localparam logic [STATUS_W-1:0] STS_LANDING_PAD  = 4'd6;
	localparam logic [STATUS_W-1:0] STS_WRITE_CLEAN  = 4'd7;
	localparam logic [STATUS_W-1:0] STS_OVERWRITE    = 4'd8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SHIFT,
		ST_FINISH
	} state_t;

endpackage

// ----- design/scsc_if.sv -----
// ----------------------------------------------------------------------------
// Shadow call stack checker channels
// Valid/ready event channel and result channel.
// ----------------------------------------------------------------------------
interface scsc_evt_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [1:0]  thread_id;
	logic [63:0] stack_ptr;
	logic [63:0] branch_target;
	logic [63:0] return_addr;
	logic [63:0] write_addr;
	logic        push_before;

	modport source (
		output valid, action, thread_id, stack_ptr, branch_target, return_addr,
		       write_addr, push_before,
		input  ready
	);
	modport sink (
		input  valid, action, thread_id, stack_ptr, branch_target, return_addr,
		       write_addr, push_before,
		output ready
	);
endinterface

interface scsc_res_if;
	logic        valid;
	logic        ready;
	logic [3:0]  status;
	logic [5:0]  match_position;
	logic [31:0] relocation_count;

	modport source (
		output valid, status, match_position, relocation_count,
		input  ready
	);
	modport sink (
		input  valid, status, match_position, relocation_count,
		output ready
	);
endinterface

// ----- design/scsc_mem.sv -----
// ----------------------------------------------------------------------------
// Shadow store memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module scsc_mem #(
	parameter int AW = 7,
	parameter int W  = 64
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [2**AW];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ----- design/shadow_call_stack_checker.sv -----
// ----------------------------------------------------------------------------
// Shadow call stack checker
// Per-thread bounded shadow stacks of stack pointers and return addresses.
// ----------------------------------------------------------------------------
// Usage:
//   evt carries one event (call, return, memory write) per request; res
//   returns one result per event, except for action code 3, which is
//   dropped without a result. Both channels move a request when valid and
//   ready are high at a rising edge of clk.
//   Each store is a circular buffer per thread in a one-read one-write
//   memory; one comparator walks it from the top, one entry per cycle.
//   A call needs no search; a memory write or return walks its store until
//   a hit or until every stored entry is read; a return that misses the
//   stack pointers walks the return addresses too, and a relocation then
//   moves the entries above the removed one down, one per cycle.
//   evt is ready only while the sequencer is idle; a finished result waits
//   in the output register, and a stalled res holds the next result back.
//   arst_n clears all counts, pointers and the relocation counter; no
//   clearing pass runs, entries are only read below the counts.
// ----------------------------------------------------------------------------
module shadow_call_stack_checker #(
	parameter int STACK_DEPTH = 32,
	parameter int THREADS     = 4
) (
	input  logic clk,
	input  logic arst_n,
	scsc_evt_if.sink   evt,
	scsc_res_if.source res
);
	import scsc_pkg::*;

	localparam int DW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
	localparam int AW = TW + DW;
	localparam int PW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

	function automatic logic [TW-1:0] tmod(input logic [1:0] v);
		logic [2:0] r;
		r = {1'b0, v};
		for (int i = 0; i < 3; i++) begin
			if (int'(r) >= THREADS) begin
				r = r - 3'(THREADS);
			end
		end
		return TW'(r);
	endfunction

	function automatic logic [DW-1:0] phys(input logic [DW-1:0] b, input logic [CW-1:0] i);
		logic [CW:0] s;
		s = (CW+1)'(b) + (CW+1)'(i);
		if (s >= (CW+1)'(STACK_DEPTH)) begin
			s = s - (CW+1)'(STACK_DEPTH);
		end
		return DW'(s);
	endfunction

	function automatic logic [DW-1:0] bump(input logic [DW-1:0] b);
		return (b == DW'(STACK_DEPTH - 1)) ? '0 : b + 1'b1;
	endfunction

	state_t state_q, state_d;

	logic [1:0]          act_q;
	logic [TW-1:0]       tid_q;
	logic [63:0]         key_q;
	logic [63:0]         tgt_q;
	logic                push_q;
	logic                sel_ra_q;
	logic [CW-1:0]       iss_k_q;
	logic                cmp_v_s1;
	logic [CW-1:0]       cmp_k_s1;
	logic [CW-1:0]       mv_k_q;
	logic                mv_v_s1;
	logic [DW-1:0]       mv_dst_s1;
	logic [STATUS_W-1:0] status_q;
	logic [CW-1:0]       pos_q;
	logic [RELOC_W-1:0]  reloc_q;
	logic [DW-1:0]       sp_base_q [THREADS];
	logic [CW-1:0]       sp_cnt_q  [THREADS];
	logic [DW-1:0]       ra_base_q [THREADS];
	logic [CW-1:0]       ra_cnt_q  [THREADS];
	logic                res_valid_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [POS_W-1:0]    res_pos_q;
	logic [RELOC_W-1:0]  res_reloc_q;

	logic          accept;
	logic [TW-1:0] evt_tid;
	logic [DW-1:0] e_sp_base, e_ra_base, cur_sp_base, cur_ra_base, srch_base;
	logic [CW-1:0] e_sp_cnt, e_ra_cnt, cur_sp_cnt, cur_ra_cnt, srch_cnt;
	logic          issue, hit, miss, mv_issue, mv_done, res_free;
	logic [63:0]   sp_rd, ra_rd, cmp_rd, cmp_key;
	logic          sp_we, ra_we;
	logic [AW-1:0] sp_waddr, ra_waddr, sp_raddr, ra_raddr, srch_addr;
	logic [63:0]   ra_wdata;
	logic [PW-1:0] pos_ext;

	assign accept    = evt.valid && evt.ready;
	assign evt.ready = (state_q == ST_IDLE);
	assign evt_tid   = tmod(evt.thread_id);

	assign e_sp_base   = sp_base_q[evt_tid];
	assign e_sp_cnt    = sp_cnt_q[evt_tid];
	assign e_ra_base   = ra_base_q[evt_tid];
	assign e_ra_cnt    = ra_cnt_q[evt_tid];
	assign cur_sp_base = sp_base_q[tid_q];
	assign cur_sp_cnt  = sp_cnt_q[tid_q];
	assign cur_ra_base = ra_base_q[tid_q];
	assign cur_ra_cnt  = ra_cnt_q[tid_q];
	assign srch_base   = sel_ra_q ? cur_ra_base : cur_sp_base;
	assign srch_cnt    = sel_ra_q ? cur_ra_cnt : cur_sp_cnt;

	assign cmp_rd  = sel_ra_q ? ra_rd : sp_rd;
	assign cmp_key = sel_ra_q ? tgt_q : key_q;
	assign hit     = (state_q == ST_SEARCH) && cmp_v_s1 && (cmp_rd == cmp_key);
	assign miss    = (state_q == ST_SEARCH) && !cmp_v_s1 && (iss_k_q >= srch_cnt);
	assign issue   = (state_q == ST_SEARCH) && !hit && (iss_k_q < srch_cnt);

	assign mv_issue = (state_q == ST_SHIFT) && (mv_k_q < cur_ra_cnt);
	assign mv_done  = (state_q == ST_SHIFT) && !mv_issue && !mv_v_s1;
	assign res_free = !res_valid_q || res.ready;

	assign srch_addr = {tid_q, phys(srch_base, srch_cnt - iss_k_q - 1'b1)};
	assign sp_raddr  = srch_addr;
	assign ra_raddr  = (state_q == ST_SHIFT) ? {tid_q, phys(cur_ra_base, mv_k_q)} : srch_addr;

	assign sp_we    = accept && (evt.action == ACT_CALL);
	assign sp_waddr = {evt_tid, phys(e_sp_base, e_sp_cnt)};
	assign ra_we    = sp_we || mv_v_s1;
	assign ra_waddr = mv_v_s1 ? {tid_q, mv_dst_s1} : {evt_tid, phys(e_ra_base, e_ra_cnt)};
	assign ra_wdata = mv_v_s1 ? ra_rd : evt.return_addr;

	scsc_mem #(.AW(AW), .W(DATA_W)) u_sp_mem (
		.clk   (clk),
		.we    (sp_we),
		.waddr (sp_waddr),
		.wdata (evt.stack_ptr),
		.raddr (sp_raddr),
		.rdata (sp_rd)
	);

	scsc_mem #(.AW(AW), .W(DATA_W)) u_ra_mem (
		.clk   (clk),
		.we    (ra_we),
		.waddr (ra_waddr),
		.wdata (ra_wdata),
		.raddr (ra_raddr),
		.rdata (ra_rd)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (evt.action == ACT_CALL) begin
						state_d = ST_FINISH;
					end else if (evt.action == ACT_RET || evt.action == ACT_WRITE) begin
						state_d = ST_SEARCH;
					end
				end
			end
			ST_SEARCH: begin
				if (hit) begin
					state_d = (sel_ra_q && cmp_k_s1 != '0) ? ST_SHIFT : ST_FINISH;
				end else if (miss) begin
					if (!(act_q == ACT_RET && !push_q && !sel_ra_q)) begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_SHIFT: begin
				if (mv_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (res_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_k_q  <= '0;
			cmp_v_s1 <= 1'b0;
			mv_v_s1  <= 1'b0;
			sel_ra_q <= 1'b0;
			tid_q    <= '0;
			reloc_q  <= '0;
			for (int i = 0; i < THREADS; i++) begin
				sp_base_q[i] <= '0;
				sp_cnt_q[i]  <= '0;
				ra_base_q[i] <= '0;
				ra_cnt_q[i]  <= '0;
			end
		end else begin
			cmp_v_s1 <= issue;
			mv_v_s1  <= mv_issue;
			if (issue) begin
				iss_k_q <= iss_k_q + 1'b1;
			end else if (hit || miss) begin
				iss_k_q <= '0;
			end
			if (accept) begin
				sel_ra_q <= 1'b0;
				tid_q    <= evt_tid;
				if (evt.action == ACT_CALL) begin
					if (e_sp_cnt == DEPTH_C) begin
						sp_base_q[evt_tid] <= bump(e_sp_base);
					end else begin
						sp_cnt_q[evt_tid] <= e_sp_cnt + 1'b1;
					end
					if (e_ra_cnt == DEPTH_C) begin
						ra_base_q[evt_tid] <= bump(e_ra_base);
					end else begin
						ra_cnt_q[evt_tid] <= e_ra_cnt + 1'b1;
					end
				end
			end
			if (hit || miss) begin
				if (!sel_ra_q && act_q == ACT_RET) begin
					if (push_q) begin
						if (cur_sp_cnt != '0) begin
							sp_cnt_q[tid_q] <= cur_sp_cnt - 1'b1;
						end
					end else if (hit) begin
						sp_cnt_q[tid_q] <= cur_sp_cnt - cmp_k_s1 - 1'b1;
					end else begin
						sel_ra_q <= 1'b1;
					end
				end
				if (sel_ra_q && hit) begin
					if (reloc_q != '1) begin
						reloc_q <= reloc_q + 1'b1;
					end
					if (cmp_k_s1 == '0) begin
						ra_cnt_q[tid_q] <= cur_ra_cnt - 1'b1;
					end
				end
			end
			if (mv_done) begin
				ra_cnt_q[tid_q] <= cur_ra_cnt - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_k_s1  <= iss_k_q;
		mv_dst_s1 <= phys(cur_ra_base, mv_k_q - 1'b1);
		if (mv_issue) begin
			mv_k_q <= mv_k_q + 1'b1;
		end
		if (accept) begin
			act_q  <= evt.action;
			key_q  <= (evt.action == ACT_WRITE) ? evt.write_addr : evt.stack_ptr;
			tgt_q  <= evt.branch_target;
			push_q <= evt.push_before;
			pos_q  <= '0;
			status_q <= (e_sp_cnt == DEPTH_C || e_ra_cnt == DEPTH_C) ?
			            STS_CALL_DROPPED : STS_CALL_PUSHED;
		end
		if (hit || miss) begin
			pos_q <= hit ? cmp_k_s1 : '0;
			if (act_q == ACT_WRITE) begin
				status_q <= hit ? STS_OVERWRITE : STS_WRITE_CLEAN;
			end else if (sel_ra_q) begin
				status_q <= hit ? STS_RELOCATED : STS_LANDING_PAD;
				mv_k_q   <= cur_ra_cnt - cmp_k_s1;
			end else if (push_q) begin
				status_q <= STS_PUSH_POP;
			end else if (hit) begin
				status_q <= (cmp_k_s1 == '0) ? STS_RET_TOP : STS_RET_BELOW;
			end
		end
	end

	assign pos_ext = PW'(pos_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && res_free) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && res_free) begin
			res_status_q <= status_q;
			res_pos_q    <= (pos_ext > PW'(63)) ? POS_W'(63) : pos_ext[POS_W-1:0];
			res_reloc_q  <= reloc_q;
		end
	end

	assign res.valid            = res_valid_q;
	assign res.status           = res_status_q;
	assign res.match_position   = res_pos_q;
	assign res.relocation_count = res_reloc_q;

	a_sp_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cur_sp_cnt <= DEPTH_C && cur_ra_cnt <= DEPTH_C)
		else $error("shadow store count above depth");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> cmp_k_s1 < srch_cnt)
		else $error("search hit beyond stored entries");

	a_reloc_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> reloc_q >= $past(reloc_q))
		else $error("relocation count decreased");

	a_shift_only_ra: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> (sel_ra_q && act_q == ACT_RET && !push_q))
		else $error("entry move outside a relocated return");
endmodule

// ----- tb/tb_scsc_if.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench request and result types
// Request and expected result records used by the shadow stack testbench.
// ----------------------------------------------------------------------------
package tb_scsc_pkg;

	typedef struct packed {
		logic [1:0]  action;
		logic [1:0]  thread_id;
		logic [63:0] stack_ptr;
		logic [63:0] branch_target;
		logic [63:0] return_addr;
		logic [63:0] write_addr;
		logic        push_before;
	} req_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [5:0]  match_position;
		logic [31:0] relocation_count;
	} verdict_t;

endpackage

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Shadow call stack checker testbench
// Drives call, return and write requests over several threads, predicts the
// status, match position and relocation count of each, and compares results.
// ----------------------------------------------------------------------------
module tb;
	import scsc_pkg::*;
	import tb_scsc_pkg::*;

	localparam int DEPTH = 32;
	localparam int NTHR  = 4;
	localparam logic [1:0] ACT_NONE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	scsc_evt_if evt ();
	scsc_res_if res ();

	shadow_call_stack_checker #(.STACK_DEPTH(DEPTH), .THREADS(NTHR)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt.sink),
		.res    (res.source)
	);

	always #6 clk = ~clk;

	logic [63:0] sp_store [NTHR][DEPTH];
	logic [63:0] ra_store [NTHR][DEPTH];
	int          sp_depth [NTHR];
	int          ra_depth [NTHR];
	logic [31:0] reloc_total;

	verdict_t pending [$];
	int       errors;
	bit       hold_res;

	task automatic report(input string what);
		$display("mismatch: %s", what);
		errors++;
	endtask

	function automatic int search_top(input logic [63:0] keys [DEPTH], input int n,
			input logic [63:0] key);
		for (int k = 0; k < n; k++)
			if (keys[n - 1 - k] == key)
				return k;
		return -1;
	endfunction

	function automatic logic [5:0] clip_pos(input int p);
		if (p < 0)
			return 6'd0;
		if (p > 63)
			return 6'd63;
		return p[5:0];
	endfunction

	function automatic verdict_t shadow_predict(input req_t r);
		verdict_t v;
		int t;
		int p;
		int idx;
		bit d1;
		bit d2;
		t = r.thread_id % NTHR;
		p = -1;
		v = '0;
		if (r.action == ACT_CALL) begin
			d1 = sp_depth[t] >= DEPTH;
			if (d1) begin
				for (int i = 0; i < DEPTH - 1; i++)
					sp_store[t][i] = sp_store[t][i + 1];
				sp_depth[t] = DEPTH - 1;
			end
			sp_store[t][sp_depth[t]] = r.stack_ptr;
			sp_depth[t]++;
			d2 = ra_depth[t] >= DEPTH;
			if (d2) begin
				for (int i = 0; i < DEPTH - 1; i++)
					ra_store[t][i] = ra_store[t][i + 1];
				ra_depth[t] = DEPTH - 1;
			end
			ra_store[t][ra_depth[t]] = r.return_addr;
			ra_depth[t]++;
			v.status = (d1 || d2) ? STS_CALL_DROPPED : STS_CALL_PUSHED;
		end else if (r.action == ACT_RET) begin
			p = search_top(sp_store[t], sp_depth[t], r.stack_ptr);
			if (r.push_before) begin
				if (sp_depth[t] > 0)
					sp_depth[t]--;
				v.status = STS_PUSH_POP;
			end else if (p >= 0) begin
				v.status = (p == 0) ? STS_RET_TOP : STS_RET_BELOW;
				sp_depth[t] -= p + 1;
			end else begin
				p = search_top(ra_store[t], ra_depth[t], r.branch_target);
				if (p >= 0) begin
					idx = ra_depth[t] - 1 - p;
					for (int i = idx; i < ra_depth[t] - 1; i++)
						ra_store[t][i] = ra_store[t][i + 1];
					ra_depth[t]--;
					if (reloc_total != 32'hFFFF_FFFF)
						reloc_total++;
					v.status = STS_RELOCATED;
				end else begin
					v.status = STS_LANDING_PAD;
				end
			end
		end else begin
			p = search_top(sp_store[t], sp_depth[t], r.write_addr);
			v.status = (p >= 0) ? STS_OVERWRITE : STS_WRITE_CLEAN;
		end
		v.match_position = clip_pos(p);
		v.relocation_count = reloc_total;
		return v;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// pick from a small pool so hits happen often
	function automatic logic [63:0] pool_addr();
		if ($urandom_range(0, 9) == 0)
			return rand64();
		return 64'h7fff_0000 + 64'($urandom_range(0, 40)) * 8;
	endfunction

	function automatic req_t mk(input logic [1:0] a, input logic [1:0] t,
			input logic [63:0] sp, input logic [63:0] bt, input logic [63:0] ra,
			input logic [63:0] wa, input logic pb);
		req_t r;
		r.action = a;
		r.thread_id = t;
		r.stack_ptr = sp;
		r.branch_target = bt;
		r.return_addr = ra;
		r.write_addr = wa;
		r.push_before = pb;
		return r;
	endfunction

	task automatic send(input req_t r, input bit known, input verdict_t want);
		verdict_t v;
		int gap;
		gap = ($urandom_range(0, 9) < 6) ? 0 :
			(($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 4));
		if (gap > 0) begin
			evt.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt.valid <= 1'b1;
		evt.action <= r.action;
		evt.thread_id <= r.thread_id;
		evt.stack_ptr <= r.stack_ptr;
		evt.branch_target <= r.branch_target;
		evt.return_addr <= r.return_addr;
		evt.write_addr <= r.write_addr;
		evt.push_before <= r.push_before;
		do @(posedge clk); while (!evt.ready);
		if (r.action != ACT_NONE) begin
			v = shadow_predict(r);
			if (known && v != want)
				report($sformatf("predictor disagrees with table, status %0d", v.status));
			pending.push_back(v);
		end
	endtask

	typedef struct packed {
		req_t     r;
		bit       known;
		verdict_t want;
	} row_t;

	initial begin
		row_t rows [$];
		req_t r;
		logic [1:0] t;
		evt.valid = 1'b0;
		evt.action = ACT_CALL;
		evt.thread_id = '0;
		evt.stack_ptr = '0;
		evt.branch_target = '0;
		evt.return_addr = '0;
		evt.write_addr = '0;
		evt.push_before = 1'b0;
		errors = 0;
		reloc_total = '0;
		for (int i = 0; i < NTHR; i++) begin
			sp_depth[i] = 0;
			ra_depth[i] = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows.push_back('{mk(ACT_RET, 0, 64'h10, 64'h20, 0, 0, 0), 1,
			'{STS_LANDING_PAD, 6'd0, 32'd0}});
		rows.push_back('{mk(ACT_RET, 1, 64'h10, 0, 0, 0, 1), 1,
			'{STS_PUSH_POP, 6'd0, 32'd0}});
		rows.push_back('{mk(ACT_WRITE, 2, 0, 0, 0, '1, 0), 1,
			'{STS_WRITE_CLEAN, 6'd0, 32'd0}});
		rows.push_back('{mk(ACT_CALL, 3, '1, 0, '1, 0, 0), 1,
			'{STS_CALL_PUSHED, 6'd0, 32'd0}});
		rows.push_back('{mk(ACT_CALL, 3, 64'h0, 0, 64'h0, 0, 0), 1,
			'{STS_CALL_PUSHED, 6'd0, 32'd0}});
		rows.push_back('{mk(ACT_WRITE, 3, 0, 0, 0, '1, 0), 1,
			'{STS_OVERWRITE, 6'd1, 32'd0}});
		rows.push_back('{mk(ACT_NONE, 3, '1, '1, '1, '1, 1), 0, '0});
		rows.push_back('{mk(ACT_RET, 3, 64'h5, '1, 0, 0, 0), 1,
			'{STS_RELOCATED, 6'd1, 32'd1}});
		rows.push_back('{mk(ACT_RET, 3, '1, 0, 0, 0, 0), 1,
			'{STS_RET_BELOW, 6'd1, 32'd1}});
		for (int i = 0; i < DEPTH + 2; i++)
			rows.push_back('{mk(ACT_CALL, 0, 64'h100 + i, 0, 64'h900 + i, 0, 0), 0, '0});
		rows.push_back('{mk(ACT_RET, 0, 64'h102, 0, 0, 0, 0), 1,
			'{STS_RET_BELOW, 6'd31, 32'd1}});
		rows.push_back('{mk(ACT_RET, 0, 64'h1, 0, 0, 0, 1), 0, '0});
		foreach (rows[i])
			send(rows[i].r, rows[i].known, rows[i].want);

		for (int n = 0; n < 1600; n++) begin
			t = 2'($urandom_range(0, 3));
			case ($urandom_range(0, 19))
				0: r = mk(ACT_NONE, t, rand64(), rand64(), rand64(), rand64(),
					1'($urandom()));
				1, 2, 3, 4, 5, 6, 7, 8:
					r = mk(ACT_CALL, t, pool_addr(), rand64(), pool_addr(), rand64(),
						1'($urandom()));
				9, 10, 11, 12, 13, 14, 15, 16: begin
					r = mk(ACT_RET, t, pool_addr(), pool_addr(), rand64(), rand64(), 0);
					r.push_before = ($urandom_range(0, 7) == 0);
				end
				default: r = mk(ACT_WRITE, t, rand64(), rand64(), rand64(), pool_addr(),
					1'($urandom()));
			endcase
			send(r, 0, '0);
		end
		evt.valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (3 * DEPTH + 20) @(posedge clk);
		if (errors == 0 && pending.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// long hold-off of the result side once, plus random stalls
	initial begin
		hold_res = 1'b0;
		wait (arst_n);
		repeat (300) @(posedge clk);
		hold_res <= 1'b1;
		repeat (400) @(posedge clk);
		hold_res <= 1'b0;
	end

	initial begin
		res.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_res)
				res.ready <= 1'b0;
			else if ($urandom_range(0, 9) < 7)
				res.ready <= 1'b1;
			else
				res.ready <= ($urandom_range(0, 29) == 0) ? 1'b0 : 1'b0;
		end
	end

	always @(posedge clk) begin
		verdict_t exp_v;
		if (arst_n && res.valid && res.ready) begin
			if (pending.size() == 0) begin
				report("result with nothing expected");
			end else begin
				exp_v = pending.pop_front();
				if (res.status !== exp_v.status)
					report($sformatf("status %0d want %0d", res.status, exp_v.status));
				if (res.match_position !== exp_v.match_position)
					report($sformatf("position %0d want %0d", res.match_position,
						exp_v.match_position));
				if (res.relocation_count !== exp_v.relocation_count)
					report($sformatf("relocations %0d want %0d", res.relocation_count,
						exp_v.relocation_count));
			end
		end
	end

	initial begin
		#(12 * 2000000);
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/scsc_pkg.sv
design/scsc_if.sv
design/scsc_mem.sv
design/shadow_call_stack_checker.sv
tb/tb_scsc_if.sv
tb/tb.sv
